// File: hdl/sitl_pkg.sv
// ----------------------------------------------------------------------------
// sitl_pkg: shared types and constants for the sorted id table lookup
// table geometry, request codes, entry layout and sequencer states
// ----------------------------------------------------------------------------
package sitl_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int POS_W       = 9;

	// request codes
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// one stored entry: frame id and its load order
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] pos;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_LK_RD,
		ST_LK_CMP
	} state_t;

endpackage

// File: hdl/sitl_ram.sv
// ----------------------------------------------------------------------------
// sitl_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sitl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/sorted_id_table_lookup_top.sv
// ----------------------------------------------------------------------------
// sorted_id_table_lookup_top: sorted frame id table with binary search lookup
// keeps ids ascending by insertion sort, one shared compare unit and one ram
// ----------------------------------------------------------------------------
//
// channel   | ports                      | handshake
// ----------+----------------------------+-----------------------------------
// request   | mode, key                  | taken when start && !busy
// result    | position, found, refused   | valid for one cycle while done
//
// clear, unused mode, full-table insert and empty-table lookup finish straight
//   from idle; an insert moves each greater entry up one slot through the
//   read and compare states, a lookup probes the midpoint of its window in
//   the same two states until it matches, misses or the window empties
// the single ram read port and the key comparator serve both; reset
//   clears only the entry count, the sequencer and done, busy drops with done
// ----------------------------------------------------------------------------
module sorted_id_table_lookup_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [sitl_pkg::KEY_W-1:0]   key,
	output logic                         done,
	output logic [sitl_pkg::POS_W-1:0]   position,
	output logic                         found,
	output logic                         refused
);

	// sequencer and counters
	sitl_pkg::state_t state_q, state_d;
	logic [sitl_pkg::CNT_W-1:0]  count_q, count_d;   // entries held
	logic [sitl_pkg::CNT_W-1:0]  idx_q, idx_d;       // insert hole position
	logic [sitl_pkg::CNT_W-1:0]  lo_q, lo_d;         // search window low
	logic [sitl_pkg::CNT_W-1:0]  hi_q, hi_d;         // search window high
	logic [sitl_pkg::ADDR_W-1:0] mid_q, mid_d;       // probed entry
	logic [sitl_pkg::KEY_W-1:0]  key_q, key_d;

	// result registers
	logic                        done_q, done_d;
	logic [sitl_pkg::POS_W-1:0]  position_q, position_d;
	logic                        found_q, found_d;
	logic                        refused_q, refused_d;

	// ram interface
	logic                          ram_we;
	logic [sitl_pkg::ADDR_W-1:0]   ram_waddr;
	logic [sitl_pkg::ADDR_W-1:0]   ram_raddr;
	sitl_pkg::entry_t              ram_wentry;
	sitl_pkg::entry_t              ram_rentry;
	logic [sitl_pkg::ENTRY_W-1:0]  ram_rdata;

	// shared compare unit and midpoint
	logic                          key_lt, key_gt;
	logic [sitl_pkg::CNT_W:0]      mid_sum;
	logic [sitl_pkg::ADDR_W-1:0]   mid_calc;
	logic                          accept;

	assign accept     = start && (state_q == sitl_pkg::ST_IDLE);
	assign ram_rentry = sitl_pkg::entry_t'(ram_rdata);
	assign key_lt     = key_q < ram_rentry.key;
	assign key_gt     = key_q > ram_rentry.key;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_calc   = mid_sum[sitl_pkg::ADDR_W:1];

	sitl_ram #(
		.WIDTH (sitl_pkg::ENTRY_W),
		.DEPTH (sitl_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sitl_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode == sitl_pkg::MODE_INSERT &&
					    count_q < sitl_pkg::CNT_W'(sitl_pkg::TABLE_DEPTH)) begin
						state_d = sitl_pkg::ST_INS_RD;
					end else if (mode == sitl_pkg::MODE_LOOKUP &&
					             count_q != '0) begin
						state_d = sitl_pkg::ST_LK_RD;
					end
				end
			end
			sitl_pkg::ST_INS_RD: begin
				if (idx_q == '0) begin
					state_d = sitl_pkg::ST_IDLE;
				end else begin
					state_d = sitl_pkg::ST_INS_CMP;
				end
			end
			sitl_pkg::ST_INS_CMP: begin
				if (key_lt) begin
					state_d = sitl_pkg::ST_INS_RD;
				end else begin
					state_d = sitl_pkg::ST_IDLE;
				end
			end
			sitl_pkg::ST_LK_RD: begin
				if (lo_q > hi_q) begin
					state_d = sitl_pkg::ST_IDLE;
				end else begin
					state_d = sitl_pkg::ST_LK_CMP;
				end
			end
			sitl_pkg::ST_LK_CMP: begin
				if (key_lt && mid_q != '0) begin
					state_d = sitl_pkg::ST_LK_RD;
				end else if (key_gt) begin
					state_d = sitl_pkg::ST_LK_RD;
				end else begin
					state_d = sitl_pkg::ST_IDLE;
				end
			end
			default: state_d = sitl_pkg::ST_IDLE;
		endcase
	end

	// datapath controls and register updates
	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = idx_q[sitl_pkg::ADDR_W-1:0];
		ram_wentry.key = key_q;
		ram_wentry.pos = count_q[sitl_pkg::ADDR_W-1:0];
		ram_raddr      = sitl_pkg::ADDR_W'(idx_q - sitl_pkg::CNT_W'(1));
		count_d        = count_q;
		idx_d          = idx_q;
		lo_d           = lo_q;
		hi_d           = hi_q;
		mid_d          = mid_q;
		key_d          = key_q;
		done_d         = 1'b0;
		position_d     = position_q;
		found_d        = found_q;
		refused_d      = refused_q;
		unique case (state_q)
			sitl_pkg::ST_IDLE: begin
				if (accept) begin
					key_d     = key;
					idx_d     = count_q;
					lo_d      = '0;
					hi_d      = count_q - sitl_pkg::CNT_W'(1);
					found_d   = 1'b0;
					refused_d = 1'b0;
					unique case (mode)
						sitl_pkg::MODE_CLEAR: begin
							count_d    = '0;
							done_d     = 1'b1;
							position_d = '0;
						end
						sitl_pkg::MODE_INSERT: begin
							// full table: refuse right away
							if (count_q >= sitl_pkg::CNT_W'(sitl_pkg::TABLE_DEPTH)) begin
								done_d     = 1'b1;
								refused_d  = 1'b1;
								position_d = sitl_pkg::POS_W'(count_q);
							end
						end
						sitl_pkg::MODE_LOOKUP: begin
							// empty table misses with no probe
							if (count_q == '0) begin
								done_d     = 1'b1;
								position_d = '0;
							end
						end
						default: begin
							done_d     = 1'b1;
							position_d = sitl_pkg::POS_W'(count_q);
						end
					endcase
				end
			end
			sitl_pkg::ST_INS_RD: begin
				// hole reached the bottom: drop the new id there
				if (idx_q == '0) begin
					ram_we     = 1'b1;
					count_d    = count_q + sitl_pkg::CNT_W'(1);
					done_d     = 1'b1;
					position_d = sitl_pkg::POS_W'(count_q + sitl_pkg::CNT_W'(1));
				end
			end
			sitl_pkg::ST_INS_CMP: begin
				ram_we = 1'b1;
				if (key_lt) begin
					// move the greater entry up into the hole
					ram_wentry = ram_rentry;
					idx_d      = idx_q - sitl_pkg::CNT_W'(1);
				end else begin
					count_d    = count_q + sitl_pkg::CNT_W'(1);
					done_d     = 1'b1;
					position_d = sitl_pkg::POS_W'(count_q + sitl_pkg::CNT_W'(1));
				end
			end
			sitl_pkg::ST_LK_RD: begin
				ram_raddr = mid_calc;
				mid_d     = mid_calc;
				if (lo_q > hi_q) begin
					done_d     = 1'b1;
					position_d = sitl_pkg::POS_W'(count_q);
				end
			end
			sitl_pkg::ST_LK_CMP: begin
				if (key_lt) begin
					if (mid_q == '0) begin
						done_d     = 1'b1;
						position_d = sitl_pkg::POS_W'(count_q);
					end else begin
						hi_d = sitl_pkg::CNT_W'(mid_q) - sitl_pkg::CNT_W'(1);
					end
				end else if (key_gt) begin
					lo_d = sitl_pkg::CNT_W'(mid_q) + sitl_pkg::CNT_W'(1);
				end else begin
					done_d     = 1'b1;
					found_d    = 1'b1;
					position_d = sitl_pkg::POS_W'(ram_rentry.pos);
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitl_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		mid_q      <= mid_d;
		key_q      <= key_d;
		position_q <= position_d;
		found_q    <= found_d;
		refused_q  <= refused_d;
	end

	assign busy     = (state_q != sitl_pkg::ST_IDLE);
	assign done     = done_q;
	assign position = position_q;
	assign found    = found_q;
	assign refused  = refused_q;

`ifndef SYNTHESIS
	// a result never both matches and refuses
	a_found_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && refused))
		else $error("found and refused both set");

	// entry count never exceeds the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sitl_pkg::CNT_W'(sitl_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// the table is written only by an insert
	a_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == sitl_pkg::ST_INS_RD || state_q == sitl_pkg::ST_INS_CMP))
		else $error("table write outside insert");

	// a refusal only happens with a full table
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && refused) |-> (count_q == sitl_pkg::CNT_W'(sitl_pkg::TABLE_DEPTH)))
		else $error("insert refused with room left");

	// a finished search or insert returns to idle with the result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == sitl_pkg::ST_IDLE))
		else $error("result out while sequencer busy");
`endif

endmodule
